@@ rtl/core/gap_pkg.sv @@
// Shared types, constants and heuristic table for the grid A* planner core.
package gap_pkg;

  localparam int unsigned CELLS     = 64;
  localparam int unsigned CELL_W    = 6;
  localparam int unsigned COST_W    = 10;
  localparam int unsigned HEUR_W    = 15;
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned F_W       = 19;
  localparam int unsigned ORDER_W   = 7;
  localparam int unsigned LEN_W     = 7;

  localparam logic [COST_W-1:0] COST_STRAIGHT = 10'd10;
  localparam logic [COST_W-1:0] COST_DIAG     = 10'd14;

  // Neighbor offsets: four straight steps, then four diagonal steps.
  localparam logic signed [2:0] STEP_DX [8] = '{3'sd1, 3'sd0, -3'sd1, 3'sd0,
                                                3'sd1, -3'sd1, -3'sd1, 3'sd1};
  localparam logic signed [2:0] STEP_DY [8] = '{3'sd0, 3'sd1, 3'sd0, -3'sd1,
                                                3'sd1, 3'sd1, -3'sd1, -3'sd1};

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_MARK   = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_READ   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_REACHED   = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_BEYOND    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_MAX_X  = 2'd0,
    REG_MAX_Y  = 2'd1,
    REG_CORNER = 2'd2
  } reg_idx_e;

  typedef logic [HEUR_W-1:0] heur_lut_t [CELLS];

  // h = floor(sqrt(100 * (dx^2 + dy^2) * 2^16)), indexed by {dy, dx}.
  function automatic heur_lut_t build_heur_lut();
    heur_lut_t   lut;
    longint unsigned v;
    longint unsigned r;
    longint unsigned b;
    for (int i = 0; i < CELLS; i++) begin
      v = longint'((i % 8) * (i % 8) + (i / 8) * (i / 8)) * 100 * 65536;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      lut[i] = r[HEUR_W-1:0];
    end
    return lut;
  endfunction

  localparam heur_lut_t HEUR_LUT = build_heur_lut();

endpackage

@@ rtl/core/grid_astar_planner_core.sv @@
// Grid A* planner core: 8x8 map, 8-connected search, stored path read-back.
// Flow: clear and mark act on acceptance, a path read passes through the read state,
//   and a search repeats expansions (open-set scan over all cells, decide, check and
//   update each neighbor), then walks back and stores the path cell by cell.
// Throughput: one transaction at a time; input is taken only when idle and no result waits.
// Reset: async active low; map free, registers at 7/7/0, stored path empty.
module grid_astar_planner_core
  import gap_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cell_x[2:0], cell_y[5:3], goal_x[8:6], goal_y[11:9], step_index[17:12], zero pad
  input  logic [23:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // path_length[6:0], path_cost[16:7], out_x[19:17], out_y[22:20], zero pad
  output logic [23:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_EVAL  = 8'b0000_0100,
    S_NBCHK = 8'b0000_1000,
    S_NBUPD = 8'b0001_0000,
    S_PW    = 8'b0010_0000,
    S_PR    = 8'b0100_0000,
    S_RD    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [2:0] max_x_q, max_y_q;
  logic       corner_q;

  // flag vectors, each cleared as a whole at once
  logic [CELLS-1:0] blocked_q, open_q, closed_q;

  // per-cell memories, one write and one registered read per cycle
  logic [COST_W-1:0]  cost_mem   [CELLS];
  logic [CELL_W:0]    parent_mem [CELLS];   // {parent valid, parent cell}
  logic [ORDER_W-1:0] order_mem  [CELLS];
  logic [CELL_W-1:0]  path_mem   [CELLS];

  logic [COST_W-1:0]  cost_rd_q;
  logic [CELL_W:0]    parent_rd_q;
  logic [ORDER_W-1:0] order_rd_q;
  logic [CELL_W-1:0]  path_rd_q;

  // search context
  logic [2:0]         gx_q, gy_q;
  logic [ORDER_W-1:0] seq_q;
  logic [LEN_W-1:0]   scan_q;
  logic               sv_q;
  logic [CELL_W-1:0]  sc_c_q;
  logic               found_q;
  logic [F_W-1:0]     bf_q;
  logic [ORDER_W-1:0] border_q;
  logic [CELL_W-1:0]  cur_q;
  logic [COST_W-1:0]  gcur_q;
  logic [2:0]         nb_i_q;
  logic [CELL_W-1:0]  nb_n_q;
  logic               nb_diag_q;
  logic               reached_q;
  logic [CELL_W-1:0]  pn_q;
  logic [LEN_W-1:0]   pcnt_q;
  logic [LEN_W-1:0]   stored_len_q;
  logic [COST_W-1:0]  final_cost_q;
  logic [CELL_W-1:0]  rd_k_q;

  // result register
  logic               out_v_q;
  logic [1:0]         out_st_q;
  logic [LEN_W-1:0]   out_len_q;
  logic [COST_W-1:0]  out_cost_q;
  logic [2:0]         out_x_q, out_y_q;

  // input fields
  logic [1:0] kind;
  logic [2:0] in_x, in_y, in_gx, in_gy;
  logic [5:0] in_k;
  logic       in_acc, out_acc;

  assign kind  = s_axis_tuser;
  assign in_x  = s_axis_tdata[2:0];
  assign in_y  = s_axis_tdata[5:3];
  assign in_gx = s_axis_tdata[8:6];
  assign in_gy = s_axis_tdata[11:9];
  assign in_k  = s_axis_tdata[17:12];

  assign s_axis_tready = (state_q == S_IDLE) && !out_v_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tdata  = {1'b0, out_y_q, out_x_q, out_cost_q, out_len_q};

  // scan evaluation: f = g * 2^8 + h for the cell read last cycle
  logic [2:0]     sc_dx, sc_dy;
  logic [F_W-1:0] sc_f;
  logic           sc_better;

  always_comb begin
    sc_dx = (sc_c_q[2:0] >= gx_q) ? sc_c_q[2:0] - gx_q : gx_q - sc_c_q[2:0];
    sc_dy = (sc_c_q[5:3] >= gy_q) ? sc_c_q[5:3] - gy_q : gy_q - sc_c_q[5:3];
    sc_f  = F_W'({cost_rd_q, FRAC_BITS'(0)}) + F_W'(HEUR_LUT[{sc_dy, sc_dx}]);
    sc_better = sv_q && open_q[sc_c_q] &&
                (!found_q || (sc_f < bf_q) || ((sc_f == bf_q) && (order_rd_q < border_q)));
  end

  // neighbor check
  logic signed [4:0] nx, ny;
  logic [2:0]        nx3, ny3;
  logic [CELL_W-1:0] nb_n;
  logic              nb_ok;
  logic [COST_W-1:0] tc;

  always_comb begin
    nx    = 5'(signed'({2'b00, cur_q[2:0]})) + 5'(STEP_DX[nb_i_q]);
    ny    = 5'(signed'({2'b00, cur_q[5:3]})) + 5'(STEP_DY[nb_i_q]);
    nx3   = nx[2:0];
    ny3   = ny[2:0];
    nb_n  = {ny3, nx3};
    nb_ok = !nx[4] && !ny[4] && (nx[3:0] <= {1'b0, max_x_q}) &&
            (ny[3:0] <= {1'b0, max_y_q}) && !blocked_q[nb_n] && !closed_q[nb_n];
    if (nb_i_q[2] && corner_q &&
        (blocked_q[{ny3, cur_q[2:0]}] || blocked_q[{cur_q[5:3], nx3}])) begin
      nb_ok = 1'b0;
    end
    tc = gcur_q + (nb_diag_q ? COST_DIAG : COST_STRAIGHT);
  end

  // memory port control
  logic               cost_we, par_we, ord_we, path_we;
  logic [CELL_W-1:0]  w_addr;
  logic [COST_W-1:0]  cost_wd;
  logic [CELL_W:0]    par_wd;
  logic [CELL_W-1:0]  cost_ra;

  always_comb begin
    cost_we = 1'b0;
    par_we  = 1'b0;
    ord_we  = 1'b0;
    path_we = (state_q == S_PW);
    w_addr  = nb_n_q;
    cost_wd = tc;
    par_wd  = {1'b1, cur_q};
    if (state_q == S_IDLE) begin
      w_addr  = {in_y, in_x};
      cost_wd = '0;
      par_wd  = '0;
      if (in_acc && kind == KIND_SEARCH) begin
        cost_we = 1'b1;
        par_we  = 1'b1;
        ord_we  = 1'b1;
      end
    end else if (state_q == S_NBUPD) begin
      if (!open_q[nb_n_q]) begin
        cost_we = 1'b1;
        par_we  = 1'b1;
        ord_we  = 1'b1;
      end else if (tc < cost_rd_q) begin
        cost_we = 1'b1;
        par_we  = 1'b1;
      end
    end
    cost_ra = (state_q == S_SCAN) ? scan_q[CELL_W-1:0] : nb_n;
  end

  always_ff @(posedge clk_i) begin
    if (cost_we) cost_mem[w_addr] <= cost_wd;
    if (par_we)  parent_mem[w_addr] <= par_wd;
    if (ord_we)  order_mem[w_addr] <= (state_q == S_IDLE) ? '0 : seq_q;
    if (path_we) path_mem[pcnt_q[CELL_W-1:0]] <= pn_q;
    cost_rd_q   <= cost_mem[cost_ra];
    order_rd_q  <= order_mem[scan_q[CELL_W-1:0]];
    parent_rd_q <= parent_mem[pn_q];
    path_rd_q   <= path_mem[in_k];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (kind)
            KIND_SEARCH: state_d = S_SCAN;
            KIND_READ:   state_d = S_RD;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN:  if (scan_q == LEN_W'(CELLS)) state_d = S_EVAL;
      S_EVAL: begin
        if (!found_q || (cur_q == {gy_q, gx_q})) state_d = S_PW;
        else state_d = S_NBCHK;
      end
      S_NBCHK: begin
        if (nb_ok) state_d = S_NBUPD;
        else if (nb_i_q == 3'd7) state_d = S_SCAN;
      end
      S_NBUPD: begin
        if (nb_i_q == 3'd7) state_d = S_SCAN;
        else state_d = S_NBCHK;
      end
      S_PW:    state_d = S_PR;
      S_PR: begin
        if (!parent_rd_q[CELL_W] || (pcnt_q + 1'b1 >= LEN_W'(CELLS))) state_d = S_IDLE;
        else state_d = S_PW;
      end
      S_RD:    state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      max_x_q      <= 3'd7;
      max_y_q      <= 3'd7;
      corner_q     <= 1'b0;
      blocked_q    <= '0;
      open_q       <= '0;
      closed_q     <= '0;
      stored_len_q <= '0;
      out_v_q      <= 1'b0;
      sv_q         <= 1'b0;
      found_q      <= 1'b0;
      scan_q       <= '0;
    end else begin
      state_q <= state_d;
      // result becomes valid at the end of a path walk or a path read
      if ((state_q == S_PR && state_d == S_IDLE) || state_q == S_RD) out_v_q <= 1'b1;
      else if (out_acc) out_v_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MAX_X:  max_x_q  <= cfg_wdata_i;
          REG_MAX_Y:  max_y_q  <= cfg_wdata_i;
          REG_CORNER: corner_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      sv_q <= (state_q == S_SCAN) && (scan_q != LEN_W'(CELLS));
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            unique case (kind)
              KIND_CLEAR: blocked_q <= '0;
              KIND_MARK:  blocked_q[{in_y, in_x}] <= 1'b1;
              KIND_SEARCH: begin
                open_q   <= CELLS'(1) << {in_y, in_x};
                closed_q <= '0;
                scan_q   <= '0;
                found_q  <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_q != LEN_W'(CELLS)) scan_q <= scan_q + 1'b1;
          if (sc_better) found_q <= 1'b1;
        end
        S_EVAL: begin
          if (found_q && (cur_q != {gy_q, gx_q})) begin
            open_q[cur_q]   <= 1'b0;
            closed_q[cur_q] <= 1'b1;
          end
        end
        S_NBCHK: begin
          if (!nb_ok && nb_i_q == 3'd7) begin
            scan_q  <= '0;
            found_q <= 1'b0;
          end
        end
        S_NBUPD: begin
          if (!open_q[nb_n_q]) open_q[nb_n_q] <= 1'b1;
          if (nb_i_q == 3'd7) begin
            scan_q  <= '0;
            found_q <= 1'b0;
          end
        end
        S_PR: begin
          if (state_d == S_IDLE) stored_len_q <= pcnt_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && kind == KIND_SEARCH) begin
          gx_q  <= in_gx;
          gy_q  <= in_gy;
          seq_q <= ORDER_W'(1);
        end
        rd_k_q <= in_k;
      end
      S_SCAN: begin
        sc_c_q <= scan_q[CELL_W-1:0];
        if (sc_better) begin
          bf_q     <= sc_f;
          border_q <= order_rd_q;
          cur_q    <= sc_c_q;
          gcur_q   <= cost_rd_q;
        end
      end
      S_EVAL: begin
        nb_i_q    <= '0;
        reached_q <= found_q;
        pn_q      <= cur_q;
        pcnt_q    <= '0;
      end
      S_NBCHK: begin
        nb_n_q    <= nb_n;
        nb_diag_q <= nb_i_q[2];
        if (!nb_ok) nb_i_q <= nb_i_q + 1'b1;
      end
      S_NBUPD: begin
        if (!open_q[nb_n_q]) seq_q <= seq_q + 1'b1;
        nb_i_q <= nb_i_q + 1'b1;
      end
      S_PR: begin
        pcnt_q <= pcnt_q + 1'b1;
        pn_q   <= parent_rd_q[CELL_W-1:0];
        if (state_d == S_IDLE) begin
          final_cost_q <= gcur_q;
          out_st_q     <= reached_q && (cur_q == {gy_q, gx_q}) ? ST_REACHED : ST_EXHAUSTED;
          out_len_q    <= pcnt_q + 1'b1;
          out_cost_q   <= gcur_q;
          out_x_q      <= cur_q[2:0];
          out_y_q      <= cur_q[5:3];
        end
      end
      S_RD: begin
        out_len_q  <= stored_len_q;
        out_cost_q <= (stored_len_q != '0) ? final_cost_q : '0;
        if (LEN_W'(rd_k_q) < stored_len_q) begin
          out_st_q <= ST_REACHED;
          out_x_q  <= path_rd_q[2:0];
          out_y_q  <= path_rd_q[5:3];
        end else begin
          out_st_q <= ST_BEYOND;
          out_x_q  <= '0;
          out_y_q  <= '0;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_no_accept_while_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !s_axis_tready) else $error("input taken while result pending");
  a_open_closed_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(open_q & closed_q) == 0) else $error("cell both open and closed");
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_len_q <= LEN_W'(CELLS)) else $error("stored path too long");
  a_scan_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NBUPD && nb_i_q == 3'd7) |=> (state_q == S_SCAN && scan_q == '0))
    else $error("scan did not restart");
`endif

endmodule

@@ dv/grid_astar_planner_core_tb.sv @@
// Self-checking testbench for the grid A* planner core: stream stimulus, path predictor, scoreboard.
`timescale 1ns / 1ps

module grid_astar_planner_core_tb;
  import gap_pkg::*;

  typedef struct packed {
    kind_e    kind;
    logic [2:0] cx;
    logic [2:0] cy;
    logic [2:0] gx;
    logic [2:0] gy;
    logic [5:0] step;
  } plan_item_t;

  typedef struct packed {
    status_e    status;
    logic [6:0] len;
    logic [9:0] cost;
    logic [2:0] x;
    logic [2:0] y;
  } plan_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [2:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // cell_x, cell_y, goal_x, goal_y, step_index, pad
  logic [1:0]  s_axis_tuser;   // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // path_length, path_cost, out_x, out_y, pad
  logic [1:0]  m_axis_tuser;   // status

  grid_astar_planner_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the map, search scratch and stored path.
  // ---------------------------------------------------------------------------
  logic [2:0] mdl_max_x, mdl_max_y;
  logic       mdl_corner;
  bit         blocked   [64];
  int         g_cost    [64];
  int         parent    [64];
  bit         has_parent[64];
  int         ins_order [64];
  bit         is_open   [64];
  bit         is_closed [64];
  int         path_cells[64];
  int         path_len;

  plan_item_t   item_q[$];     // pending input transactions
  plan_result_t result_q[$];   // results still owed by the core
  int           errors;

  // Test control
  bit hold_send;     // sender pauses while set
  bit calm;          // no random idling on either side
  bit want_hold;     // request one long receiver hold-off
  int hold_cnt;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("grid_astar_planner_core test failed");
    $finish;
  end

  // 10 * Euclidean distance, 8 fraction bits, rounded down.
  function automatic longint unsigned dist_heur(int x, int y, int gx, int gy);
    longint unsigned v, r, b;
    v = longint'((x - gx) * (x - gx) + (y - gy) * (y - gy)) * 100 * 65536;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit cell_valid(int x, int y);
    return x >= 0 && y >= 0 && x < 8 && y < 8 && x <= mdl_max_x && y <= mdl_max_y;
  endfunction

  function automatic plan_result_t plan_search(int sx, int sy, int gx, int gy);
    plan_result_t    res;
    int              seq, cur, n, nx, ny, cx, cy, tc, cnt;
    bit              found;
    longint unsigned f, bf;
    seq = 0;
    cur = 0;
    for (int c = 0; c < 64; c++) begin
      is_open[c]   = 0;
      is_closed[c] = 0;
    end
    n = sx + sy * 8;
    is_open[n] = 1;
    g_cost[n] = 0;
    has_parent[n] = 0;
    ins_order[n] = seq++;
    res.status = ST_EXHAUSTED;
    forever begin
      found = 0;
      bf = 0;
      for (int c = 0; c < 64; c++) begin
        if (is_open[c]) begin
          f = (longint'(g_cost[c]) << FRAC_BITS) + dist_heur(c % 8, c / 8, gx, gy);
          // earliest insertion wins a tie on f
          if (!found || f < bf || (f == bf && ins_order[c] < ins_order[cur])) begin
            found = 1;
            bf = f;
            cur = c;
          end
        end
      end
      if (!found) break;
      cx = cur % 8;
      cy = cur / 8;
      if (cx == gx && cy == gy) begin
        res.status = ST_REACHED;
        break;
      end
      is_open[cur]   = 0;
      is_closed[cur] = 1;
      for (int i = 0; i < 8; i++) begin
        nx = cx + STEP_DX[i];
        ny = cy + STEP_DY[i];
        if (!cell_valid(nx, ny)) continue;
        n = nx + ny * 8;
        if (blocked[n] || is_closed[n]) continue;
        // corner guard looks at the two side cells of a diagonal move
        if (i > 3 && mdl_corner && (blocked[cx + ny * 8] || blocked[nx + cy * 8])) continue;
        tc = g_cost[cur] + (i < 4 ? 10 : 14);
        if (!is_open[n]) begin
          is_open[n] = 1;
          g_cost[n] = tc;
          parent[n] = cur;
          has_parent[n] = 1;
          ins_order[n] = seq++;
        end else if (tc < g_cost[n]) begin
          g_cost[n] = tc;
          parent[n] = cur;
          has_parent[n] = 1;
        end
      end
    end
    // walk back from the final node
    n = cur;
    cnt = 0;
    forever begin
      path_cells[cnt++] = n;
      if (!has_parent[n] || cnt >= 64) break;
      n = parent[n];
    end
    path_len = cnt;
    res.len  = 7'(cnt);
    res.cost = (g_cost[cur] > 1023) ? 10'd1023 : 10'(g_cost[cur]);
    res.x    = 3'(cur % 8);
    res.y    = 3'(cur / 8);
    return res;
  endfunction

  task automatic predict_item(plan_item_t it);
    plan_result_t res;
    case (it.kind)
      KIND_CLEAR: for (int c = 0; c < 64; c++) blocked[c] = 0;
      KIND_MARK:  blocked[it.cx + it.cy * 8] = 1;
      KIND_SEARCH: result_q.insert(result_q.size(), plan_search(it.cx, it.cy, it.gx, it.gy));
      default: begin
        res.len  = 7'(path_len);
        res.cost = '0;
        if (path_len > 0)
          res.cost = (g_cost[path_cells[0]] > 1023) ? 10'd1023 : 10'(g_cost[path_cells[0]]);
        if (it.step < path_len) begin
          res.status = ST_REACHED;
          res.x = 3'(path_cells[it.step] % 8);
          res.y = 3'(path_cells[it.step] / 8);
        end else begin
          res.status = ST_BEYOND;
          res.x = '0;
          res.y = '0;
        end
        result_q.insert(result_q.size(), res);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued items, predicts each accepted transaction.
  // ---------------------------------------------------------------------------
  plan_item_t drv_item;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_item(drv_item);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (!hold_send && item_q.size() > 0 && (calm || $urandom_range(99) >= 20)) begin
          drv_item = item_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'd0, drv_item.step, drv_item.gy, drv_item.gx,
                            drv_item.cy, drv_item.cx};
          s_axis_tuser  <= drv_item.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure, with one long counted hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= 0;
    end else if (hold_cnt > 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= hold_cnt - 1;
    end else if (want_hold) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= 3000;
    end else begin
      m_axis_tready <= calm || $urandom_range(99) >= 20;
    end
  end

  // Monitor: compare each result transaction with the oldest prediction.
  always @(posedge clk_i) begin
    plan_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %h / %h", m_axis_tuser, m_axis_tdata);
      end else begin
        exp_r = result_q.pop_front();
        if (m_axis_tuser != exp_r.status || m_axis_tdata[6:0] != exp_r.len ||
            m_axis_tdata[16:7] != exp_r.cost || m_axis_tdata[19:17] != exp_r.x ||
            m_axis_tdata[22:20] != exp_r.y || m_axis_tdata[23] != 1'b0) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: exp st=%0d len=%0d cost=%0d xy=%0d,%0d",
                      " got st=%0d len=%0d cost=%0d xy=%0d,%0d"},
                     exp_r.status, exp_r.len, exp_r.cost, exp_r.x, exp_r.y,
                     m_axis_tuser, m_axis_tdata[6:0], m_axis_tdata[16:7],
                     m_axis_tdata[19:17], m_axis_tdata[22:20]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------
  task automatic push(kind_e k, int cx, int cy, int gx, int gy, int st);
    plan_item_t it;
    it.kind = k;
    it.cx = 3'(cx);
    it.cy = 3'(cy);
    it.gx = 3'(gx);
    it.gy = 3'(gy);
    it.step = 6'(st);
    item_q.insert(item_q.size(), it);
  endtask

  // Block until every queued item is taken and every result is back.
  task automatic drain();
    while (item_q.size() != 0 || s_axis_tvalid || result_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);   // a trailing mark/clear has no result
  endtask

  task automatic set_regs(int mx, int my, int cg);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= REG_MAX_X;  cfg_wdata_i <= 3'(mx);
    @(posedge clk_i);
    cfg_idx_i <= REG_MAX_Y;  cfg_wdata_i <= 3'(my);
    @(posedge clk_i);
    cfg_idx_i <= REG_CORNER; cfg_wdata_i <= 3'(cg);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mdl_max_x  = 3'(mx);
    mdl_max_y  = 3'(my);
    mdl_corner = 1'(cg);
  endtask

  // Random burst: a random mix of clears, obstacle marks, searches and path reads.
  task automatic random_burst(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 4)       push(KIND_CLEAR, $urandom_range(7), $urandom_range(7),
                            $urandom_range(7), $urandom_range(7), $urandom_range(63));
      else if (r < 35) push(KIND_MARK, $urandom_range(7), $urandom_range(7),
                            $urandom_range(7), $urandom_range(7), $urandom_range(63));
      else if (r < 65) push(KIND_SEARCH, $urandom_range(7), $urandom_range(7),
                            $urandom_range(7), $urandom_range(7), $urandom_range(63));
      else if (r < 90) push(KIND_READ, $urandom_range(7), $urandom_range(7),
                            $urandom_range(7), $urandom_range(7), $urandom_range(12));
      else             push(KIND_READ, $urandom_range(7), $urandom_range(7),
                            $urandom_range(7), $urandom_range(7), $urandom_range(63));
    end
  endtask

  initial begin
    errors      = 0;
    hold_send   = 1'b0;
    calm        = 1'b0;
    want_hold   = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_MAX_X;
    cfg_wdata_i = '0;
    mdl_max_x   = 3'd7;
    mdl_max_y   = 3'd7;
    mdl_corner  = 1'b0;
    path_len    = 0;
    for (int c = 0; c < 64; c++) begin
      blocked[c] = 0;
      g_cost[c] = 0;
      parent[c] = 0;
      has_parent[c] = 0;
      path_cells[c] = 0;
    end
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset defaults, empty path reads, open, start-equals-goal, blocked and walled searches.
    push(KIND_READ,   0, 0, 0, 0, 0);
    push(KIND_READ,   7, 7, 7, 7, 63);
    push(KIND_SEARCH, 0, 0, 7, 7, 0);
    push(KIND_READ,   0, 0, 0, 0, 0);
    push(KIND_READ,   0, 0, 0, 0, 7);
    push(KIND_READ,   0, 0, 0, 0, 8);
    push(KIND_SEARCH, 3, 3, 3, 3, 0);      // start equals goal
    push(KIND_MARK,   0, 0, 0, 0, 0);
    push(KIND_MARK,   7, 7, 0, 0, 0);
    push(KIND_SEARCH, 0, 0, 7, 7, 0);      // start blocked, goal blocked
    for (int y = 0; y < 8; y++) push(KIND_MARK, 4, y, 0, 0, 0);
    push(KIND_SEARCH, 1, 1, 6, 6, 0);      // wall: open set exhausted
    push(KIND_READ,   0, 0, 0, 0, 1);
    push(KIND_CLEAR,  0, 0, 0, 0, 0);
    drain();

    // Corner guard on, diagonal past blocked corners.
    set_regs(7, 7, 1);
    push(KIND_MARK,   1, 0, 0, 0, 0);
    push(KIND_MARK,   0, 1, 0, 0, 0);
    push(KIND_SEARCH, 0, 0, 1, 1, 0);
    push(KIND_SEARCH, 2, 2, 0, 0, 0);
    push(KIND_READ,   0, 0, 0, 0, 2);
    random_burst(20);
    drain();

    // Small map, goal outside the bounds; long receiver hold-off.
    set_regs(3, 5, 0);
    push(KIND_SEARCH, 0, 0, 7, 7, 0);
    push(KIND_SEARCH, 6, 6, 0, 0, 0);      // start outside the map
    random_burst(20);
    want_hold = 1'b1;
    repeat (5) @(posedge clk_i);
    want_hold = 1'b0;
    drain();

    // Single-cell map, no idling.
    set_regs(0, 0, 1);
    calm = 1'b1;
    push(KIND_CLEAR,  0, 0, 0, 0, 0);
    push(KIND_SEARCH, 0, 0, 0, 0, 0);
    push(KIND_SEARCH, 0, 0, 1, 0, 0);
    random_burst(15);
    drain();
    calm = 1'b0;

    // Thin maps.
    set_regs(7, 0, 0);
    random_burst(15);
    drain();
    set_regs(0, 7, 1);
    random_burst(10);
    drain();

    // Random bounds and guard, then back to full map.
    set_regs($urandom_range(7), $urandom_range(7), $urandom_range(1));
    random_burst(15);
    drain();
    set_regs(7, 7, 0);
    push(KIND_CLEAR, 0, 0, 0, 0, 0);
    random_burst(15);
    drain();
    repeat (50) @(posedge clk_i);

    if (errors == 0) begin
      $display("grid_astar_planner_core test passed");
    end else begin
      $display("grid_astar_planner_core test failed");
    end
    $finish;
  end

endmodule
